>>> design/slsw_pkg.sv
// ----------------------------------------------------------------------------
// slsw_pkg: shared types and constants of the stop-and-wait link MAC
// Command codes, field widths and the command record passed from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package slsw_pkg;

  // Request queue geometry (power of two)
  localparam int QUEUE_DEPTH = 16;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = QAW + 1;

  // Field widths
  localparam int HANDLE_W = 16;
  localparam int ADDR_W   = 16;
  localparam int SEQ_W    = 7;
  localparam int TAG_BITS = 8;
  localparam int TIMER_W  = 16;
  localparam int ACTION_W = 3;
  localparam int KIND_W   = 2;

  // Command queue between front and back end
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = CMDQ_AW + 1;

  localparam logic [ADDR_W-1:0] BROADCAST_ADDR = '1;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_SEND  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RESP  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCAL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RX    = 3'd4;

  // Classified command codes
  localparam logic [2:0] OP_SEND     = 3'd0;
  localparam logic [2:0] OP_RESP     = 3'd1;
  localparam logic [2:0] OP_LOCAL    = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_RX_UP    = 3'd4;
  localparam logic [2:0] OP_RX_SNOOP = 3'd5;
  localparam logic [2:0] OP_NONE     = 3'd6;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SNOOP  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] REG_PROMISC     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   address;
    logic [SEQ_W-1:0]    resp_seq;
    logic                ok;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

endpackage

>>> design/slsw_front.sv
// ----------------------------------------------------------------------------
// slsw_front: input classifier
// Accepts input beats, sorts them into commands, filters received frames
// by address and pushes the commands that need work into the command queue.
// ----------------------------------------------------------------------------
module slsw_front (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slsw_pkg::ACTION_W-1:0]   in_action,
  input  logic [slsw_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [slsw_pkg::ADDR_W-1:0]     in_address,
  input  logic [slsw_pkg::SEQ_W-1:0]      in_resp_seq,
  input  logic                            in_ok,
  input  logic [slsw_pkg::TAG_BITS-1:0]   in_tag,
  input  logic [slsw_pkg::ADDR_W-1:0]     own_address,
  input  logic                            promiscuous,
  output logic                            push_valid,
  input  logic                            push_ready,
  output slsw_pkg::cmd_t                  push_cmd
);

  logic [2:0] op;

  // Classify the action; drop frames nobody wants and unused codes
  always_comb begin
    case (in_action)
      slsw_pkg::ACT_SEND:  op = slsw_pkg::OP_SEND;
      slsw_pkg::ACT_RESP:  op = slsw_pkg::OP_RESP;
      slsw_pkg::ACT_LOCAL: op = slsw_pkg::OP_LOCAL;
      slsw_pkg::ACT_TICK:  op = slsw_pkg::OP_TICK;
      slsw_pkg::ACT_RX: begin
        if (in_address == own_address || in_address == slsw_pkg::BROADCAST_ADDR) begin
          op = slsw_pkg::OP_RX_UP;
        end else if (promiscuous) begin
          op = slsw_pkg::OP_RX_SNOOP;
        end else begin
          op = slsw_pkg::OP_NONE;
        end
      end
      default: op = slsw_pkg::OP_NONE;
    endcase
  end

  // Hold the input while the queue is full
  assign in_stall   = !push_ready;
  assign push_valid = in_valid && push_ready && (op != slsw_pkg::OP_NONE);

  always_comb begin
    push_cmd.op       = op;
    push_cmd.handle   = in_handle;
    push_cmd.address  = in_address;
    push_cmd.resp_seq = in_resp_seq;
    push_cmd.ok       = in_ok;
    push_cmd.tag      = in_tag;
  end

endmodule

>>> design/slsw_cmdq.sv
// ----------------------------------------------------------------------------
// slsw_cmdq: command queue
// Short FIFO of classified commands between the front and back end.
// ----------------------------------------------------------------------------
module slsw_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  slsw_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output slsw_pkg::cmd_t pop_cmd
);

  slsw_pkg::cmd_t                   slot_r [slsw_pkg::CMDQ_DEPTH];
  logic [slsw_pkg::CMDQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [slsw_pkg::CMDQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [slsw_pkg::CMDQ_CW-1:0]     count_r, count_nxt;
  logic                             do_push, do_pop;

  assign push_ready = (count_r != slsw_pkg::CMDQ_CW'(slsw_pkg::CMDQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/slsw_back.sv
// ----------------------------------------------------------------------------
// slsw_back: transmit manager back end
// Executes one command at a time against the request queue, sequence,
// tag and response timer, and emits up to two result beats.
// ----------------------------------------------------------------------------
module slsw_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  slsw_pkg::cmd_t                  cmd_in,
  input  logic [slsw_pkg::TIMER_W-1:0]    response_timeout,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slsw_pkg::KIND_W-1:0]     out_kind,
  output logic [slsw_pkg::HANDLE_W-1:0]   out_handle,
  output logic [slsw_pkg::ADDR_W-1:0]     out_address,
  output logic [slsw_pkg::SEQ_W-1:0]      out_seq_out,
  output logic [slsw_pkg::TAG_BITS-1:0]   out_tag_out,
  output logic                            out_success,
  output logic                            out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ANS  = 2'd2;
  localparam logic [1:0] S_SND  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  slsw_pkg::cmd_t                  cmd_r, cmd_nxt;

  // Request queue storage
  logic [slsw_pkg::HANDLE_W-1:0]   hmem [slsw_pkg::QUEUE_DEPTH];
  logic [slsw_pkg::ADDR_W-1:0]     amem [slsw_pkg::QUEUE_DEPTH];
  logic [slsw_pkg::HANDLE_W-1:0]   rd_handle_r;
  logic [slsw_pkg::ADDR_W-1:0]     rd_address_r;
  logic                            mem_we;
  logic [slsw_pkg::QAW-1:0]        mem_waddr;

  logic [slsw_pkg::QAW-1:0]        head_r, head_nxt;
  logic [slsw_pkg::QCW-1:0]        count_r, count_nxt;
  logic [slsw_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic [slsw_pkg::TAG_BITS-1:0]   tag_r, tag_nxt;
  logic                            tag_valid_r, tag_valid_nxt;
  logic                            armed_r, armed_nxt;
  logic [slsw_pkg::TIMER_W-1:0]    left_r, left_nxt;

  // Pending first beat (answer or received frame) and pending send
  logic                            a_pend_r, a_pend_nxt;
  logic [slsw_pkg::KIND_W-1:0]     a_kind_r, a_kind_nxt;
  logic [slsw_pkg::HANDLE_W-1:0]   a_handle_r, a_handle_nxt;
  logic [slsw_pkg::ADDR_W-1:0]     a_address_r, a_address_nxt;
  logic                            a_success_r, a_success_nxt;
  logic                            s_pend_r, s_pend_nxt;

  // Output register
  logic                            ov_r, ov_nxt;
  logic [slsw_pkg::KIND_W-1:0]     o_kind_r, o_kind_nxt;
  logic [slsw_pkg::HANDLE_W-1:0]   o_handle_r, o_handle_nxt;
  logic [slsw_pkg::ADDR_W-1:0]     o_address_r, o_address_nxt;
  logic [slsw_pkg::SEQ_W-1:0]      o_seq_r, o_seq_nxt;
  logic [slsw_pkg::TAG_BITS-1:0]   o_tag_r, o_tag_nxt;
  logic                            o_success_r, o_success_nxt;
  logic                            o_last_r, o_last_nxt;

  logic                            load_ok;
  logic                            pop_ans;
  logic                            send_chk;

  assign load_ok = !ov_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = head_r + count_r[slsw_pkg::QAW-1:0];
    head_nxt      = head_r;
    count_nxt     = count_r;
    seq_nxt       = seq_r;
    tag_nxt       = tag_r;
    tag_valid_nxt = tag_valid_r;
    armed_nxt     = armed_r;
    left_nxt      = left_r;
    a_pend_nxt    = a_pend_r;
    a_kind_nxt    = a_kind_r;
    a_handle_nxt  = a_handle_r;
    a_address_nxt = a_address_r;
    a_success_nxt = a_success_r;
    s_pend_nxt    = s_pend_r;
    pop_ans       = 1'b0;
    send_chk      = 1'b0;
    ov_nxt        = ov_r && out_stall;
    o_kind_nxt    = o_kind_r;
    o_handle_nxt  = o_handle_r;
    o_address_nxt = o_address_r;
    o_seq_nxt     = o_seq_r;
    o_tag_nxt     = o_tag_r;
    o_success_nxt = o_success_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      // Take the next command
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_in;
          state_nxt = S_EXEC;
        end
      end

      // Update the transmit state and decide which beats to emit
      S_EXEC: begin
        a_pend_nxt    = 1'b0;
        s_pend_nxt    = 1'b0;
        a_kind_nxt    = slsw_pkg::KIND_ANSWER;
        a_handle_nxt  = cmd_r.handle;
        a_address_nxt = '0;
        a_success_nxt = 1'b0;
        case (cmd_r.op)
          slsw_pkg::OP_SEND: begin
            if (count_r == slsw_pkg::QCW'(slsw_pkg::QUEUE_DEPTH)) begin
              a_pend_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
              send_chk  = (count_r == '0);
            end
          end
          slsw_pkg::OP_RESP: begin
            if (cmd_r.resp_seq == seq_r) begin
              pop_ans       = (count_r != '0);
              a_success_nxt = cmd_r.ok;
              armed_nxt     = 1'b0;
              left_nxt      = '0;
              send_chk      = 1'b1;
            end
          end
          slsw_pkg::OP_LOCAL: begin
            if (tag_valid_r && cmd_r.tag == tag_r) begin
              if (cmd_r.ok) begin
                armed_nxt = 1'b1;
                left_nxt  = response_timeout;
              end else if (count_r != '0) begin
                tag_valid_nxt = 1'b0;
                pop_ans       = 1'b1;
                send_chk      = 1'b1;
              end
            end
          end
          slsw_pkg::OP_TICK: begin
            if (armed_r) begin
              if (left_r <= slsw_pkg::TIMER_W'(1)) begin
                armed_nxt = 1'b0;
                left_nxt  = '0;
                pop_ans   = (count_r != '0);
                send_chk  = 1'b1;
              end else begin
                left_nxt = left_r - 1'b1;
              end
            end
          end
          slsw_pkg::OP_RX_UP: begin
            a_pend_nxt    = 1'b1;
            a_kind_nxt    = slsw_pkg::KIND_UP;
            a_address_nxt = cmd_r.address;
          end
          slsw_pkg::OP_RX_SNOOP: begin
            a_pend_nxt    = 1'b1;
            a_kind_nxt    = slsw_pkg::KIND_SNOOP;
            a_address_nxt = cmd_r.address;
          end
          default: begin
          end
        endcase

        // Answer the head and drop it
        if (pop_ans) begin
          a_pend_nxt   = 1'b1;
          a_handle_nxt = rd_handle_r;
          head_nxt     = head_r + 1'b1;
          count_nxt    = count_r - 1'b1;
        end

        // Start the next transfer if anything is queued
        if (send_chk && count_nxt != '0) begin
          s_pend_nxt    = 1'b1;
          seq_nxt       = seq_r + 1'b1;
          tag_nxt       = tag_r + 1'b1;
          tag_valid_nxt = 1'b1;
        end
        state_nxt = S_ANS;
      end

      // Emit the answer or received-frame beat
      S_ANS: begin
        if (!a_pend_r) begin
          state_nxt = S_SND;
        end else if (load_ok) begin
          ov_nxt        = 1'b1;
          o_kind_nxt    = a_kind_r;
          o_handle_nxt  = a_handle_r;
          o_address_nxt = a_address_r;
          o_seq_nxt     = '0;
          o_tag_nxt     = '0;
          o_success_nxt = a_success_r;
          o_last_nxt    = !s_pend_r;
          state_nxt     = S_SND;
        end
      end

      // Emit the frame for the new head
      S_SND: begin
        if (!s_pend_r) begin
          state_nxt = S_IDLE;
        end else if (load_ok) begin
          ov_nxt        = 1'b1;
          o_kind_nxt    = slsw_pkg::KIND_SEND;
          o_handle_nxt  = rd_handle_r;
          o_address_nxt = rd_address_r;
          o_seq_nxt     = seq_r;
          o_tag_nxt     = tag_r;
          o_success_nxt = 1'b0;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      seq_r       <= '0;
      tag_r       <= '0;
      tag_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      left_r      <= '0;
      a_pend_r    <= 1'b0;
      s_pend_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      tag_r       <= tag_nxt;
      tag_valid_r <= tag_valid_nxt;
      armed_r     <= armed_nxt;
      left_r      <= left_nxt;
      a_pend_r    <= a_pend_nxt;
      s_pend_r    <= s_pend_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    a_kind_r    <= a_kind_nxt;
    a_handle_r  <= a_handle_nxt;
    a_address_r <= a_address_nxt;
    a_success_r <= a_success_nxt;
    o_kind_r    <= o_kind_nxt;
    o_handle_r  <= o_handle_nxt;
    o_address_r <= o_address_nxt;
    o_seq_r     <= o_seq_nxt;
    o_tag_r     <= o_tag_nxt;
    o_success_r <= o_success_nxt;
    o_last_r    <= o_last_nxt;
  end

  // Request queue: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hmem[mem_waddr] <= cmd_r.handle;
      amem[mem_waddr] <= cmd_r.address;
    end
    rd_handle_r  <= hmem[head_r];
    rd_address_r <= amem[head_r];
  end

  assign out_valid   = ov_r;
  assign out_kind    = o_kind_r;
  assign out_handle  = o_handle_r;
  assign out_address = o_address_r;
  assign out_seq_out = o_seq_r;
  assign out_tag_out = o_tag_r;
  assign out_success = o_success_r;
  assign out_last    = o_last_r;

endmodule

>>> design/serial_link_stop_and_wait_mac_unit.sv
// ----------------------------------------------------------------------------
// serial_link_stop_and_wait_mac_unit: stop-and-wait transmit manager
// Queues send requests, sends the head with sequence number and transfer
// tag, tracks local results, remote responses and a response timer, and
// filters received frames by address.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  action, handle, address, resp_seq, ok, tag
//  out      output     out_valid / out_stall kind, handle, address, seq, tag, success, last
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
//  The back end steps through its take, execute, answer slot and send
//  slot states for each command whatever beats it emits; a stalled
//  output beat holds it in that slot. The front end is combinational and
//  drops unused frames and codes. A two-entry command queue takes input beats
//  while results wait; in_stall rises only when that queue is full. Reset
//  is synchronous and clears all control state; queue contents start undefined.
// ----------------------------------------------------------------------------
module serial_link_stop_and_wait_mac_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slsw_pkg::ACTION_W-1:0]   in_action,
  input  logic [slsw_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [slsw_pkg::ADDR_W-1:0]     in_address,
  input  logic [slsw_pkg::SEQ_W-1:0]      in_resp_seq,
  input  logic                            in_ok,
  input  logic [slsw_pkg::TAG_BITS-1:0]   in_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slsw_pkg::KIND_W-1:0]     out_kind,
  output logic [slsw_pkg::HANDLE_W-1:0]   out_handle,
  output logic [slsw_pkg::ADDR_W-1:0]     out_address,
  output logic [slsw_pkg::SEQ_W-1:0]      out_seq_out,
  output logic [slsw_pkg::TAG_BITS-1:0]   out_tag_out,
  output logic                            out_success,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_wdata
);

  logic [slsw_pkg::ADDR_W-1:0]  own_address_r;
  logic                         promisc_r;
  logic [slsw_pkg::TIMER_W-1:0] timeout_r;

  logic                         push_valid, push_ready;
  slsw_pkg::cmd_t               push_cmd;
  logic                         pop_valid, pop;
  slsw_pkg::cmd_t               pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      promisc_r     <= 1'b0;
      timeout_r     <= slsw_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        slsw_pkg::REG_OWN_ADDRESS: own_address_r <= cfg_wdata[slsw_pkg::ADDR_W-1:0];
        slsw_pkg::REG_PROMISC:     promisc_r     <= cfg_wdata[0];
        slsw_pkg::REG_TIMEOUT:     timeout_r     <= cfg_wdata[slsw_pkg::TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slsw_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_handle   (in_handle),
    .in_address  (in_address),
    .in_resp_seq (in_resp_seq),
    .in_ok       (in_ok),
    .in_tag      (in_tag),
    .own_address (own_address_r),
    .promiscuous (promisc_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  slsw_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  slsw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (pop_valid),
    .cmd_pop          (pop),
    .cmd_in           (pop_cmd),
    .response_timeout (timeout_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_handle       (out_handle),
    .out_address      (out_address),
    .out_seq_out      (out_seq_out),
    .out_tag_out      (out_tag_out),
    .out_success      (out_success),
    .out_last         (out_last)
  );

endmodule
